/* rtl/ddmw_pkg.sv */
// Shared types, constants and mixing functions for the differential drive mixer.
package ddmw_pkg;

    localparam int DUTY_FULL  = 8192;
    localparam int SPEED_MAX  = 100;
    localparam int Q_ONE      = 16384;
    localparam int Q_SHIFT    = 14;
    localparam int DUTY_W     = 14;
    localparam int SPEED_W    = 7;
    localparam int CMD_W      = 16;
    localparam int ELAPSED_W  = 16;
    localparam int TIMEOUT_W  = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(500);
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = {ELAPSED_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_DRIVE = 2'd0,
        FUNC_STOP  = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic {
        REG_TIMEOUT = 1'b0,
        REG_UNUSED  = 1'b1
    } reg_idx_t;

    typedef logic [DUTY_W-1:0] duty_table_t [SPEED_MAX+1];

    typedef struct packed {
        logic [DUTY_W-1:0] fwd;
        logic [DUTY_W-1:0] rev;
    } wheel_t;

    typedef struct packed {
        logic              tripped;
        logic              moving;
        logic [DUTY_W-1:0] right_reverse;
        logic [DUTY_W-1:0] right_forward;
        logic [DUTY_W-1:0] left_reverse;
        logic [DUTY_W-1:0] left_forward;
    } result_t;

    function automatic duty_table_t make_duty_table();
        duty_table_t t;
        for (int i = 0; i <= SPEED_MAX; i++)
        begin
            t[i] = DUTY_W'(i * DUTY_FULL / SPEED_MAX);
        end
        return t;
    endfunction

    localparam duty_table_t DUTY_TABLE = make_duty_table();

    function automatic logic signed [CMD_W:0] clamp_q(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W:0] w;
        w = {v[CMD_W-1], v};
        if (w > (CMD_W+1)'(Q_ONE))
            return (CMD_W+1)'(Q_ONE);
        if (w < -(CMD_W+1)'(Q_ONE))
            return -(CMD_W+1)'(Q_ONE);
        return w;
    endfunction

    function automatic wheel_t mix_wheel(input logic signed [CMD_W:0] sum);
        logic [CMD_W-1:0]          mag;
        logic [CMD_W+SPEED_W-1:0]  scaled;
        logic [CMD_W+SPEED_W-Q_SHIFT-1:0] speed_raw;
        logic [SPEED_W-1:0]        speed;
        logic [DUTY_W-1:0]         duty;
        wheel_t                    w;
        mag = sum[CMD_W] ? CMD_W'(-sum) : CMD_W'(sum);
        scaled = (CMD_W+SPEED_W)'(mag) * (CMD_W+SPEED_W)'(SPEED_MAX);
        speed_raw = scaled[CMD_W+SPEED_W-1:Q_SHIFT];
        if (speed_raw > (CMD_W+SPEED_W-Q_SHIFT)'(SPEED_MAX))
            speed = SPEED_W'(SPEED_MAX);
        else
            speed = speed_raw[SPEED_W-1:0];
        duty = DUTY_TABLE[speed];
        w.fwd = (!sum[CMD_W] && speed != '0) ? duty : '0;
        w.rev = sum[CMD_W] ? duty : '0;
        return w;
    endfunction

endpackage

/* rtl/differential_drive_mixer_watchdog_unit.sv */
// Differential drive mixer with command watchdog: top level.
//
// Input stream: s_axis_tuser carries the request kind (drive, stop, tick) and
// s_axis_tdata the turn and throttle commands in Q2.14. Each request gives one
// result on the output stream: four wheel channel duties, the moving flag and
// a watchdog trip flag. A tick request stands for one millisecond.
// The request is accepted into an input register, then goes through the mixing
// and watchdog logic into the result register. One request is taken every
// cycle while the receiver keeps up; throughput is one per cycle, set by the
// single pass from the input register to the result register.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, and tready falls only when both are full.
// The APB port holds the timeout register at address 0; write it while the
// streams are idle.
// Reset clears both pipeline stages, the duties, the moving flag and the
// elapsed counter, and loads the timeout with 500 ticks.
module differential_drive_mixer_watchdog_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // turn_cmd[15:0], throttle_cmd[31:16]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // left_forward_duty[13:0], left_reverse_duty[27:14],
                                        // right_forward_duty[41:28], right_reverse_duty[55:42],
                                        // moving_flag[56], watchdog_tripped[57], zero[63:58]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DW = ddmw_pkg::DUTY_W;

    logic                                 in_valid_reg;
    logic [1:0]                           in_func_reg;
    logic signed [ddmw_pkg::CMD_W-1:0]    in_turn_reg;
    logic signed [ddmw_pkg::CMD_W-1:0]    in_throttle_reg;

    logic                                 out_valid_reg;
    ddmw_pkg::result_t                    out_reg;
    ddmw_pkg::result_t                    out_next;

    logic                                 moving_reg;
    logic                                 moving_next;
    logic [ddmw_pkg::ELAPSED_W-1:0]       elapsed_reg;
    logic [ddmw_pkg::ELAPSED_W-1:0]       elapsed_next;
    logic [DW-1:0]                        duty_reg [4];
    logic [DW-1:0]                        duty_next [4];
    logic [ddmw_pkg::TIMEOUT_W-1:0]       timeout_reg;

    logic                                 advance;
    logic                                 cfg_write;
    logic signed [ddmw_pkg::CMD_W:0]      x_clamped;
    logic signed [ddmw_pkg::CMD_W:0]      y_clamped;
    ddmw_pkg::wheel_t                     left_wheel;
    ddmw_pkg::wheel_t                     right_wheel;
    logic                                 tripped;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == ddmw_pkg::REG_TIMEOUT);
    assign prdata    = (paddr[2] == ddmw_pkg::REG_TIMEOUT)
                       ? {{(32 - ddmw_pkg::TIMEOUT_W){1'b0}}, timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= ddmw_pkg::TIMEOUT_RESET;
        else if (cfg_write)
            timeout_reg <= pwdata[ddmw_pkg::TIMEOUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_func_reg     <= s_axis_tuser;
            in_turn_reg     <= s_axis_tdata[15:0];
            in_throttle_reg <= s_axis_tdata[31:16];
        end
    end

    assign x_clamped   = ddmw_pkg::clamp_q(in_turn_reg);
    assign y_clamped   = ddmw_pkg::clamp_q(in_throttle_reg);
    assign left_wheel  = ddmw_pkg::mix_wheel(y_clamped + x_clamped);
    assign right_wheel = ddmw_pkg::mix_wheel(y_clamped - x_clamped);

    always_comb
    begin
        moving_next  = moving_reg;
        elapsed_next = elapsed_reg;
        duty_next    = duty_reg;
        tripped      = 1'b0;
        unique case (ddmw_pkg::func_t'(in_func_reg))
            ddmw_pkg::FUNC_DRIVE:
            begin
                elapsed_next = '0;
                if (in_turn_reg != '0 || in_throttle_reg != '0)
                    moving_next = 1'b1;
                duty_next[0] = left_wheel.fwd;
                duty_next[1] = left_wheel.rev;
                duty_next[2] = right_wheel.fwd;
                duty_next[3] = right_wheel.rev;
            end
            ddmw_pkg::FUNC_STOP:
            begin
                moving_next = 1'b0;
                duty_next   = '{default: '0};
            end
            ddmw_pkg::FUNC_TICK:
            begin
                if (elapsed_reg != ddmw_pkg::ELAPSED_MAX)
                    elapsed_next = elapsed_reg + 1'b1;
                if (moving_reg && elapsed_next > timeout_reg)
                begin
                    moving_next = 1'b0;
                    duty_next   = '{default: '0};
                    tripped     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        out_next.left_forward  = duty_next[0];
        out_next.left_reverse  = duty_next[1];
        out_next.right_forward = duty_next[2];
        out_next.right_reverse = duty_next[3];
        out_next.moving        = moving_next;
        out_next.tripped       = tripped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg  <= 1'b0;
            elapsed_reg <= '0;
            duty_reg    <= '{default: '0};
        end
        else if (advance)
        begin
            moving_reg  <= moving_next;
            elapsed_reg <= elapsed_next;
            duty_reg    <= duty_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    a_trip_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.tripped |->
            !out_reg.moving && out_reg.left_forward == '0 && out_reg.left_reverse == '0
            && out_reg.right_forward == '0 && out_reg.right_reverse == '0)
        else $error("watchdog trip left a wheel driven");

    a_moving_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.moving == moving_reg)
        else $error("reported moving flag differs from state");

    a_elapsed_mono: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_func_reg != ddmw_pkg::FUNC_DRIVE |=>
            elapsed_reg >= $past(elapsed_reg))
        else $error("elapsed counter went back without a drive request");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled while a stage was free");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.left_forward != '0 && out_reg.left_reverse != '0)
            && !(out_reg.right_forward != '0 && out_reg.right_reverse != '0))
        else $error("both channels of one wheel driven");

endmodule
